// ===== hdl/irtc_pkg.sv =====
// Package for the impulse relay timer control block: register indexes, field widths and the poll item type.
package irtc_pkg;

    // Width of the seconds count and of the timer registers
    localparam int unsigned SecW = 32;

    // Configuration register index width and codes
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_AUTO_OFF_ENABLE  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_AUTO_OFF_SECONDS = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MOTION_ENABLE    = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_MOTION_SECONDS   = 2'd3;

    // One poll item as held in the input register
    typedef struct packed {
        logic            toggle_level;
        logic            reset_level;
        logic            panic_level;
        logic            motion_level;
        logic            remote_valid;
        logic            remote_value;
        logic [SecW-1:0] now_seconds;
    } t_poll;

endpackage

// ===== hdl/impulse_relay_timer_control.sv =====
// Impulse relay with motion timer, auto-off timer and remote state adoption.
//
// Usage:
//   Poll channel (i_valid / o_stall): one item per poll carries the four
//   button levels, an optional remote state and the current seconds count.
//   Result channel (o_valid / i_stall): one result per poll with the output
//   state, a locally-written flag and a first-poll announce flag.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (auto-off enable, auto-off seconds, motion enable, motion seconds);
//   write only while no poll is in flight.
// Pipeline:
//   A poll enters the input register, is evaluated against the state
//   combinationally and lands in the result register. One poll is taken
//   per clock while the receiver does not stall; the state update of one
//   poll is seen by the next one.
// Reset:
//   Synchronous, active low. Output off, edge history cleared, timers and
//   configuration zero, announce pending for the first poll.
// Stall:
//   While the receiver stalls a held result, the input register fills and
//   o_stall rises; nothing is lost or repeated.
module impulse_relay_timer_control (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // poll channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_toggle_level,
    input  logic                          i_reset_level,
    input  logic                          i_panic_level,
    input  logic                          i_motion_level,
    input  logic                          i_remote_valid,
    input  logic                          i_remote_value,
    input  logic [irtc_pkg::SecW-1:0]     i_now_seconds,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_output_on,
    output logic                          o_output_written,
    output logic                          o_announce,
    // configuration port
    input  logic                          i_cfg_we,
    input  logic [irtc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [irtc_pkg::SecW-1:0]     i_cfg_data
);

    // configuration registers
    logic                      r_auto_off_enable;
    logic [irtc_pkg::SecW-1:0] r_auto_off_seconds;
    logic                      r_motion_enable;
    logic [irtc_pkg::SecW-1:0] r_motion_seconds;

    // pipeline registers
    logic             r_in_valid;
    irtc_pkg::t_poll  r_in;
    logic             r_out_valid;
    logic             r_out_on;
    logic             r_out_written;
    logic             r_out_announce;

    // block state
    logic                      r_out_state;
    logic                      r_first_pending;
    logic                      r_toggle_prev;
    logic                      r_reset_prev;
    logic                      r_panic_prev;
    logic                      r_motion_prev;
    logic                      r_motion_active;
    logic [irtc_pkg::SecW-1:0] r_motion_start;
    logic [irtc_pkg::SecW-1:0] r_auto_off_start;

    // next values from the evaluation stage
    logic                      n_out_state;
    logic                      n_written;
    logic                      n_motion_active;
    logic [irtc_pkg::SecW-1:0] n_motion_start;
    logic [irtc_pkg::SecW-1:0] n_auto_off_start;

    logic advance;
    logic in_take;
    logic motion_edge;
    logic motion_expire;
    logic panic_edge;
    logic reset_edge;
    logic toggle_edge;
    logic remote_take;
    logic auto_off_hit;
    logic st_motion;
    logic st_panic;
    logic st_reset;
    logic st_toggle;
    logic [irtc_pkg::SecW-1:0] motion_elapsed;
    logic [irtc_pkg::SecW-1:0] auto_off_elapsed;

    // pipeline flow control
    assign advance = ~r_out_valid | ~i_stall;
    assign o_stall = r_in_valid & ~advance;
    assign in_take = i_valid & ~o_stall;

    // evaluate one poll in the fixed priority order
    always_comb begin
        motion_edge    = r_motion_enable & r_in.motion_level & ~r_motion_prev & ~r_out_state;
        n_motion_start = motion_edge ? r_in.now_seconds : r_motion_start;
        motion_elapsed = r_in.now_seconds - n_motion_start;
        motion_expire  = r_motion_enable & (r_motion_active | motion_edge)
                         & (motion_elapsed >= r_motion_seconds);
        n_motion_active = r_motion_enable ? ((r_motion_active | motion_edge) & ~motion_expire)
                                          : r_motion_active;
        st_motion = motion_expire ? 1'b0 : (motion_edge ? 1'b1 : r_out_state);

        panic_edge = r_in.panic_level & ~r_panic_prev;
        st_panic   = panic_edge | st_motion;
        reset_edge = r_in.reset_level & ~r_reset_prev;
        st_reset   = st_panic & ~reset_edge;

        toggle_edge = r_in.toggle_level & ~r_toggle_prev;
        st_toggle   = st_reset ^ toggle_edge;

        remote_take = r_in.remote_valid & (r_in.remote_value != st_toggle);
        n_auto_off_start = (toggle_edge | remote_take) ? r_in.now_seconds : r_auto_off_start;
        auto_off_elapsed = r_in.now_seconds - n_auto_off_start;

        auto_off_hit = r_in.remote_valid ? r_in.remote_value : st_toggle;
        auto_off_hit = auto_off_hit & r_auto_off_enable
                       & (auto_off_elapsed >= r_auto_off_seconds);
        n_out_state  = (r_in.remote_valid ? r_in.remote_value : st_toggle) & ~auto_off_hit;

        n_written = motion_edge | motion_expire | panic_edge | reset_edge
                    | r_first_pending | toggle_edge | auto_off_hit;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_off_enable  <= 1'b0;
            r_auto_off_seconds <= '0;
            r_motion_enable    <= 1'b0;
            r_motion_seconds   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                irtc_pkg::CFG_AUTO_OFF_ENABLE:  r_auto_off_enable  <= i_cfg_data[0];
                irtc_pkg::CFG_AUTO_OFF_SECONDS: r_auto_off_seconds <= i_cfg_data;
                irtc_pkg::CFG_MOTION_ENABLE:    r_motion_enable    <= i_cfg_data[0];
                irtc_pkg::CFG_MOTION_SECONDS:   r_motion_seconds   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register: hold a poll until the evaluation stage can advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.toggle_level <= i_toggle_level;
            r_in.reset_level  <= i_reset_level;
            r_in.panic_level  <= i_panic_level;
            r_in.motion_level <= i_motion_level;
            r_in.remote_valid <= i_remote_valid;
            r_in.remote_value <= i_remote_value;
            r_in.now_seconds  <= i_now_seconds;
        end
    end

    // state update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_out_state      <= 1'b0;
            r_first_pending  <= 1'b1;
            r_toggle_prev    <= 1'b0;
            r_reset_prev     <= 1'b0;
            r_panic_prev     <= 1'b0;
            r_motion_prev    <= 1'b0;
            r_motion_active  <= 1'b0;
            r_motion_start   <= '0;
            r_auto_off_start <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_out_state      <= n_out_state;
                r_first_pending  <= 1'b0;
                r_toggle_prev    <= r_in.toggle_level;
                r_reset_prev     <= r_in.reset_level;
                r_panic_prev     <= r_in.panic_level;
                r_motion_prev    <= r_in.motion_level;
                r_motion_active  <= n_motion_active;
                r_motion_start   <= n_motion_start;
                r_auto_off_start <= n_auto_off_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_on       <= n_out_state;
            r_out_written  <= n_written;
            r_out_announce <= r_first_pending;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_output_on      = r_out_on;
    assign o_output_written = r_out_written;
    assign o_announce       = r_out_announce;

`ifndef ASSERT_OFF
    // an announced result is always a written one
    a_announce_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_announce) |-> o_output_written)
        else $error("announce without written flag");

    // once a result has announced, no later poll may announce again
    a_announce_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_announce) |-> !r_first_pending)
        else $error("announce still pending after announced result");

    // an empty result register never pushes back on the poll side
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall)
        else $error("poll side stalled with empty result register");

    // reset leaves announce pending and no result shown
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_first_pending && !o_valid && !r_in_valid))
        else $error("reset state wrong");
`endif

endmodule
